[rtl/unsigned_divider_quotient_remainder_unit_macros.svh]
// Assertion macros shared by the divider RTL.
`ifndef UNSIGNED_DIVIDER_QUOTIENT_REMAINDER_UNIT_MACROS_SVH
`define UNSIGNED_DIVIDER_QUOTIENT_REMAINDER_UNIT_MACROS_SVH

// Checks that the antecedent implies the consequent in the same cycle.
`define UDQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that the antecedent is followed by the consequent after the delay given by dly.
`define UDQ_ASSERT_DELAYED(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("assertion failed");

`endif

[rtl/udq_pkg.sv]
// Package with the widths and item types of the unsigned divider.
package udq_pkg;

    localparam int DataWidth = 32;

    typedef logic [DataWidth-1:0] word_t;

    typedef struct packed {
        word_t dividend;
        word_t divisor_value;
    } in_t;

    typedef struct packed {
        word_t quotient_value;
        word_t remainder_value;
        logic  divide_by_zero;
    } out_t;

    // Data that moves from one divider cell to the next.
    typedef struct packed {
        word_t rem;
        word_t work;
        word_t divisor;
        logic  dz;
    } stage_t;

endpackage

[rtl/udq_cell.sv]
// One restoring-division cell: resolves a single quotient bit per item.
module udq_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid_in,
    input  udq_pkg::stage_t stage_in,
    output logic            valid_out,
    output udq_pkg::stage_t stage_out
);

    localparam int W = udq_pkg::DataWidth;

    logic            valid_reg;
    udq_pkg::stage_t stage_reg;
    udq_pkg::stage_t stage_next;
    logic [W:0]      shifted;
    logic [W+1:0]    diff;
    logic            borrow;

    // The work word holds the dividend bits still to come in its upper part and the
    // quotient bits already found in its lower part.
    always_comb
    begin
        shifted = {stage_in.rem, stage_in.work[W-1]};
        diff    = {1'b0, shifted} - {2'b00, stage_in.divisor};
        borrow  = diff[W+1];

        stage_next         = stage_in;
        stage_next.rem     = borrow ? shifted[W-1:0] : diff[W-1:0];
        stage_next.work    = {stage_in.work[W-2:0], ~borrow};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

endmodule

[rtl/unsigned_divider_quotient_remainder_unit.sv]
// Top level of the pipelined unsigned divider: a chain of one-bit cells.
// An accepted item (start high) passes through the registers of all 32 cells before its done strobe.
// Throughput: one item per cycle; each of the 32 cells resolves one quotient bit.
// busy is never raised, and the result shows for exactly one cycle with done.
// Reset clears only the per-cell valid bits; payload registers are not reset.
// A zero divisor yields an all-ones quotient, the dividend as remainder, and the flag.
`include "unsigned_divider_quotient_remainder_unit_macros.svh"

module unsigned_divider_quotient_remainder_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  udq_pkg::in_t  operands,
    output logic          busy,
    output logic          done,
    output udq_pkg::out_t result
);

    localparam int W       = udq_pkg::DataWidth;
    localparam int Latency = udq_pkg::DataWidth;

    logic            valid_chain [0:W];
    udq_pkg::stage_t stage_chain [0:W];

    always_comb
    begin
        valid_chain[0]         = start;
        stage_chain[0].rem     = '0;
        stage_chain[0].work    = operands.dividend;
        stage_chain[0].divisor = operands.divisor_value;
        stage_chain[0].dz      = (operands.divisor_value == '0);
    end

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        udq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_chain[i]),
            .stage_in  (stage_chain[i]),
            .valid_out (valid_chain[i+1]),
            .stage_out (stage_chain[i+1])
        );
    end

    assign busy = 1'b0;
    assign done = valid_chain[W];

    assign result.quotient_value  = stage_chain[W].work;
    assign result.remainder_value = stage_chain[W].rem;
    assign result.divide_by_zero  = stage_chain[W].dz;

    `UDQ_ASSERT_DELAYED(a_start_to_done, clk, rst_n, start, Latency, done)
    `UDQ_ASSERT_IMPLIES(a_done_from_start, clk, rst_n, done, $past(start, Latency))
    `UDQ_ASSERT_IMPLIES(a_zero_divisor, clk, rst_n, done && result.divide_by_zero, (result.quotient_value == '1) && (result.remainder_value == $past(operands.dividend, Latency)))
    `UDQ_ASSERT_IMPLIES(a_rem_below_div, clk, rst_n, done && !result.divide_by_zero, result.remainder_value < $past(operands.divisor_value, Latency))

endmodule
